[hw/rtl/svst_pkg.sv]
package svst_pkg;

  localparam int VALUE_W = 32;
  localparam int SCNT_W  = 5;

  typedef enum logic [1:0] {
    OP_INSERT      = 2'd0,
    OP_REMOVE      = 2'd1,
    OP_CONTAINS    = 2'd2,
    OP_REMOVE_LAST = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic               capture;    // request taken: latch compare result
    logic               insert_en;  // append key at slot == count
    logic               remove_en;  // shift down from the matched slot
    logic [VALUE_W-1:0] key;
  } cell_cmd_t;

endpackage

[hw/rtl/svst_cell.sv]
module svst_cell
  import svst_pkg::*;
#(
  parameter int INDEX = 0,
  parameter int CNT_W = 5,
  parameter int IDX_W = 4
) (
  input  logic               clk,
  input  cell_cmd_t          cmd,
  input  logic [CNT_W-1:0]   count,
  input  logic [IDX_W-1:0]   slot,
  input  logic [VALUE_W-1:0] next_entry,
  output logic [VALUE_W-1:0] entry,
  output logic               hit,
  output logic [VALUE_W-1:0] last_value
);

  logic last;
  logic occupied;

  assign occupied   = CNT_W'(INDEX) < count;
  assign last_value = last ? entry : '0;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hit  <= occupied && (entry == cmd.key);
      last <= CNT_W'(INDEX + 1) == count;
    end
    if (cmd.insert_en && (CNT_W'(INDEX) == count)) begin
      entry <= cmd.key;
    end else if (cmd.remove_en && (IDX_W'(INDEX) >= slot)) begin
      entry <= next_entry;
    end
  end

endmodule

[hw/rtl/small_value_set_table.sv]
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tdata: value; tuser: operation
// m_*      out  m_tvalid/m_tready  tdata: taken_value, set_count; tuser: found, status
//
// Each request is compared, then applied: at the accepting edge every cell
// compares its entry with the value; in the update cycle the controller
// merges the hits and the cells append, shift down or stay, and the result
// is registered. The next request is taken once that update has been made,
// so a stalled result holds the block in its update cycle.
// rst is synchronous; it clears the entry count and the handshake flags.
// Cell contents need no reset: only cells below the count are ever read.
module small_value_set_table
  import svst_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [1:0]  s_tuser,   // [1:0] operation
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] taken_value, [36:32] set_count, rest zero
  output logic [2:0]  m_tuser    // [0] found, [2:1] status
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);

  // control
  logic               busy;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  op_t                op_q;
  logic [VALUE_W-1:0] value_q;
  logic               capture;
  logic               do_upd;

  // cell row
  cell_cmd_t          cmd;
  logic [VALUE_W-1:0] entry_arr [CAPACITY];
  logic [VALUE_W-1:0] last_arr  [CAPACITY];
  logic [CAPACITY-1:0] hit;
  logic [IDX_W-1:0]   slot;
  logic [VALUE_W-1:0] taken_any;
  logic               found_any;

  // result register
  logic               found_o;
  logic [VALUE_W-1:0] taken_o;
  logic [SCNT_W-1:0]  cnt_o;
  status_t            status_o;
  logic               found_n;
  logic [VALUE_W-1:0] taken_n;
  status_t            status_n;
  logic               insert_en;
  logic               remove_en;

  assign s_tready = !busy;
  assign capture  = s_tvalid && s_tready;
  assign do_upd   = busy && (!m_tvalid || m_tready);

  assign m_tdata  = {3'b000, cnt_o, taken_o};
  assign m_tuser  = {status_o, found_o};

  assign cmd.capture   = capture;
  assign cmd.insert_en = insert_en;
  assign cmd.remove_en = remove_en;
  assign cmd.key       = busy ? value_q : s_tdata;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_W-1:0] nxt;
    if (i == CAPACITY - 1) begin : g_end
      assign nxt = entry_arr[i];
    end else begin : g_mid
      assign nxt = entry_arr[i+1];
    end
    svst_cell #(
      .INDEX(i),
      .CNT_W(CNT_W),
      .IDX_W(IDX_W)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .count      (count),
      .slot       (slot),
      .next_entry (nxt),
      .entry      (entry_arr[i]),
      .hit        (hit[i]),
      .last_value (last_arr[i])
    );
  end

  // values are distinct, so at most one hit: OR-merge gives its index
  always_comb begin
    slot      = '0;
    taken_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit[i]) slot = slot | IDX_W'(i);
      taken_any = taken_any | last_arr[i];
    end
  end

  assign found_any = |hit;

  always_comb begin
    found_n    = found_any;
    taken_n    = '0;
    status_n   = ST_OK;
    count_next = count;
    insert_en  = 1'b0;
    remove_en  = 1'b0;
    case (op_q)
      OP_INSERT: begin
        if (!found_any) begin
          if (count == CNT_W'(CAPACITY)) begin
            status_n = ST_FULL;
          end else begin
            insert_en  = do_upd;
            count_next = count + 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        if (found_any) begin
          remove_en  = do_upd;
          count_next = count - 1'b1;
        end
      end
      OP_CONTAINS: begin
      end
      OP_REMOVE_LAST: begin
        if (count == '0) begin
          found_n  = 1'b0;
          status_n = ST_EMPTY;
        end else begin
          found_n    = 1'b1;
          taken_n    = taken_any;
          count_next = count - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (capture) begin
        busy <= 1'b1;
      end else if (do_upd) begin
        busy <= 1'b0;
      end
      if (do_upd) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      op_q    <= op_t'(s_tuser);
      value_q <= s_tdata;
    end
    if (do_upd) begin
      found_o  <= found_n;
      taken_o  <= taken_n;
      cnt_o    <= SCNT_W'(count_next);
      status_o <= status_n;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_unique_hit: assert property (@(posedge clk) disable iff (rst)
    busy |-> $onehot0(hit))
    else $error("value held in more than one cell");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    do_upd && (status_n == ST_FULL) |=> count == CNT_W'(CAPACITY))
    else $error("full reported below capacity");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    do_upd |=> m_tvalid && !busy)
    else $error("update made without a result");
`endif

endmodule

[sim/small_value_set_table_test.sv]
`timescale 1ns / 100ps

module small_value_set_table_test;
  import svst_pkg::*;

  localparam int TABLE_DEPTH  = 16;
  localparam int POOL_N       = 24;    // more than the depth, so the table fills
  localparam int HOLD_CYCLES  = 200;
  localparam int TAIL_CYCLES  = 10;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int SHOWN_ERRORS = 10;

  // one result as the block reports it
  typedef struct packed {
    logic        found;
    logic [31:0] taken;
    logic [4:0]  count;
    status_t     status;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] value
  logic [1:0]  s_tuser = '0;   // [1:0] operation
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [31:0] taken_value, [36:32] set_count, rest zero
  logic [2:0]  m_tuser;        // [0] found, [2:1] status

  // mirror of the table contents, oldest entry first
  logic [31:0] mirror_vals [TABLE_DEPTH];
  int          mirror_n = 0;
  outcome_t    pending_outcomes [$];
  logic [31:0] value_pool [POOL_N];

  int src_idle_pct  = 10;
  int sink_idle_pct = 10;
  bit hold_req      = 1'b0;
  int fail_count    = 0;

  // coverage tallies for the closing summary
  int n_requests  = 0;
  int n_hits      = 0;
  int n_full      = 0;
  int n_empty     = 0;
  int n_taken     = 0;
  int peak_fill   = 0;
  int n_op [4]    = '{0, 0, 0, 0};

  small_value_set_table #(.CAPACITY(TABLE_DEPTH)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // Works out the result of one accepted request and updates the mirror.
  function automatic outcome_t apply_request(op_t op, logic [31:0] v);
    outcome_t r;
    int       slot;
    int       i;
    r    = '0;
    slot = -1;
    if (op == OP_REMOVE_LAST) begin
      if (mirror_n == 0) begin
        r.status = ST_EMPTY;
      end else begin
        mirror_n = mirror_n - 1;
        r.taken  = mirror_vals[mirror_n];
        r.found  = 1'b1;
      end
    end else begin
      for (i = 0; i < mirror_n; i++)
        if (slot < 0 && mirror_vals[i] == v) slot = i;
      r.found = (slot >= 0);
      if (op == OP_INSERT && !r.found) begin
        if (mirror_n >= TABLE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          mirror_vals[mirror_n] = v;
          mirror_n = mirror_n + 1;
        end
      end else if (op == OP_REMOVE && r.found) begin
        // close the gap, later entries keep their order
        for (i = slot; i + 1 < mirror_n; i++) mirror_vals[i] = mirror_vals[i + 1];
        mirror_n = mirror_n - 1;
      end
    end
    r.count = 5'(mirror_n);
    return r;
  endfunction

  task automatic note_failure(string what);
    fail_count++;
    if (fail_count <= SHOWN_ERRORS) $display("ERROR @%0t: %s", $realtime, what);
  endtask

  // Offers one request, with random idle cycles first, and records its outcome
  // once it is accepted. s_tvalid stays high until an idle cycle or a drain.
  task automatic send_request(op_t op, logic [31:0] v);
    outcome_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    r = apply_request(op, v);
    pending_outcomes.push_back(r);
    n_requests++;
    n_op[op]++;
    if (r.found && op != OP_REMOVE_LAST) n_hits++;
    if (r.status == ST_FULL) n_full++;
    if (r.status == ST_EMPTY) n_empty++;
    if (op == OP_REMOVE_LAST && r.found) n_taken++;
    if (mirror_n > peak_fill) peak_fill = mirror_n;
  endtask

  // Sender pause: nothing offered until every outstanding result is back.
  task automatic await_results();
    s_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  function automatic op_t pick_op(int mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      0: begin  // filling
        if (r < 55) return OP_INSERT;
        if (r < 65) return OP_REMOVE;
        if (r < 85) return OP_CONTAINS;
        return OP_REMOVE_LAST;
      end
      1: begin  // draining
        if (r < 20) return OP_INSERT;
        if (r < 55) return OP_REMOVE;
        if (r < 70) return OP_CONTAINS;
        return OP_REMOVE_LAST;
      end
      default: return op_t'(r % 4);
    endcase
  endfunction

  // Mostly pool values and live entries so lookups hit; near misses check that
  // the whole 32-bit pattern is compared; the rest is noise.
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 55) return value_pool[$urandom_range(POOL_N - 1)];
    if (r < 70 && mirror_n > 0)
      return mirror_vals[$urandom_range(mirror_n - 1)] ^ (32'h1 << $urandom_range(31));
    if (r < 85 && mirror_n > 0) return mirror_vals[$urandom_range(mirror_n - 1)];
    return $urandom;
  endfunction

  task automatic test_directed();
    send_request(OP_REMOVE_LAST, 32'h0);        // remove-last on empty
    send_request(OP_REMOVE,      32'h0);        // remove from empty table
    send_request(OP_CONTAINS,    32'h0);
    send_request(OP_INSERT,      32'h8000_0000);
    send_request(OP_INSERT,      32'h7FFF_FFFF);
    send_request(OP_INSERT,      32'h0000_0000);
    send_request(OP_INSERT,      32'hFFFF_FFFF);
    send_request(OP_INSERT,      32'h7FFF_FFFF); // already present
    send_request(OP_CONTAINS,    32'h0000_0000);
    send_request(OP_CONTAINS,    32'h0000_0001); // one bit off an entry
    send_request(OP_CONTAINS,    32'hFFFF_FFFE);
    send_request(OP_REMOVE,      32'h7FFF_FFFF); // middle entry, gap closes
    send_request(OP_REMOVE,      32'h1234_5678); // absent
    send_request(OP_REMOVE_LAST, 32'hDEAD_BEEF);
    send_request(OP_REMOVE_LAST, 32'h0);
    send_request(OP_INSERT,      32'hA5A5_A5A5);
    send_request(OP_REMOVE,      32'h8000_0000); // oldest entry
    send_request(OP_REMOVE_LAST, 32'h0);
    send_request(OP_REMOVE_LAST, 32'h0);
    send_request(OP_REMOVE_LAST, 32'h0);
    await_results();
  endtask

  // Result side held off while the table is filled past its capacity, so the
  // block stalls its input; then full-table cases and a drain to empty.
  task automatic test_stall_fill();
    int k;
    while (mirror_n > 0) send_request(OP_REMOVE_LAST, $urandom);
    await_results();
    hold_req = 1'b1;
    wait (!hold_req);
    for (k = 0; k < TABLE_DEPTH + 4; k++) send_request(OP_INSERT, $urandom);
    send_request(OP_INSERT, mirror_vals[0]);               // present while full
    send_request(OP_CONTAINS, mirror_vals[TABLE_DEPTH - 1]);
    send_request(OP_REMOVE, mirror_vals[TABLE_DEPTH / 2]);
    send_request(OP_INSERT, 32'h5A5A_5A5A);                // refills the last slot
    while (mirror_n > 0) send_request(OP_REMOVE_LAST, 32'h0);
    send_request(OP_REMOVE_LAST, 32'h0);
    await_results();
  endtask

  // Short bursts, each followed by a full drain, so the block goes idle often.
  // The lookup pool is set up here, before its first use.
  task automatic test_bursts();
    int b;
    int k;
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h7FFF_FFFF;
    value_pool[4] = 32'h0000_0001;
    for (k = 5; k < POOL_N; k++) value_pool[k] = $urandom;
    for (b = 0; b < 8; b++) begin
      for (k = 0; k < 1 + $urandom_range(9); k++) send_request(pick_op(2), pick_value());
      await_results();
      repeat ($urandom_range(4)) @(posedge clk);
    end
  endtask

  // Segments of 50 requests alternating between filling and draining mixes, with
  // every fourth one a uniform mix; a middle stretch has no idling on either side.
  task automatic test_random();
    int seg;
    int k;
    int mode;
    for (seg = 0; seg < 32; seg++) begin
      mode = (seg % 4 == 3) ? 2 : seg % 2;
      if (seg == 12) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else if (seg == 18) begin
        src_idle_pct  = 10;
        sink_idle_pct = 10;
      end
      for (k = 0; k < 50; k++) send_request(pick_op(mode), pick_value());
    end
    await_results();
  endtask

  // Result receiver: random stalls, plus a long hold-off counted here.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Compares each accepted result with the oldest outstanding prediction.
  always @(posedge clk) begin : result_check
    outcome_t got;
    outcome_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.found  = m_tuser[0];
      got.status = status_t'(m_tuser[2:1]);
      got.taken  = m_tdata[31:0];
      got.count  = m_tdata[36:32];
      if (pending_outcomes.size() == 0) begin
        note_failure($sformatf("unexpected result found=%0b taken=%h count=%0d status=%0d",
                               got.found, got.taken, got.count, got.status));
      end else begin
        want = pending_outcomes.pop_front();
        if (got !== want || m_tdata[39:37] !== 3'b000 || ^m_tuser === 1'bx)
          note_failure($sformatf({"result mismatch: expected found=%0b taken=%h count=%0d ",
                                  "status=%0d, got found=%0b taken=%h count=%0d status=%0d ",
                                  "pad=%b"},
                                 want.found, want.taken, want.count, want.status,
                                 got.found, got.taken, got.count, got.status,
                                 m_tdata[39:37]));
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("ERROR: run did not finish within %0d cycles", CYCLE_LIMIT);
    $display("small_value_set_table_test: FAIL");
    $finish;
  end

  initial begin : main
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_stall_fill();
    test_bursts();
    test_random();
    await_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_outcomes.size() != 0)
      note_failure($sformatf("%0d results never arrived", pending_outcomes.size()));
    $display("covered %0d requests (insert %0d, remove %0d, contains %0d, remove-last %0d)",
             n_requests, n_op[OP_INSERT], n_op[OP_REMOVE], n_op[OP_CONTAINS],
             n_op[OP_REMOVE_LAST]);
    $display("lookup hits %0d, dropped on full %0d, taken %0d, empty %0d, peak fill %0d",
             n_hits, n_full, n_taken, n_empty, peak_fill);
    if (fail_count == 0) begin
      $display("small_value_set_table_test: PASS");
    end else begin
      $display("%0d failures", fail_count);
      $display("small_value_set_table_test: FAIL");
    end
    $finish;
  end

endmodule
